>>> design/npcs_pkg.sv
package npcs_pkg;

    // Number of palette entries that take part in the search (2 .. 256).
    localparam int PALETTE_SIZE = 256;
    localparam int PAL_AW       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

    localparam int CH_W   = 8;
    localparam int IDX_W  = 8;
    localparam int SQ_W   = 2 * CH_W;
    localparam int DIST_W = 18;
    localparam int RGB_W  = 3 * CH_W;

    // Larger than any reachable squared distance, so every pixel finds an entry.
    localparam logic [DIST_W-1:0] START_BEST = DIST_W'(256 * 256 * 3);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] entry_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]  color_index;
        logic [DIST_W-1:0] distance;
    } t_out_res;

    // Jump conditions of the sequencer; a taken jump goes to the target,
    // otherwise the step counter advances by one.
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_NO_PIXEL,
        COND_MORE,
        COND_OUT_BUSY
    } t_cond;

    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN0 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_RETURN = 3'd5;

    typedef struct packed {
        logic              ready;     // input side may take a request
        logic              issue;     // read the palette and advance the address
        logic              out_load;  // move the best match to the output register
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uop;

    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{ready: 1'b0, issue: 1'b0, out_load: 1'b0,
              cond: COND_ALWAYS, target: STEP_FETCH};
        unique case (step)
            STEP_FETCH: begin
                u.ready  = 1'b1;
                u.cond   = COND_NO_PIXEL;
                u.target = STEP_FETCH;
            end
            STEP_SCAN: begin
                u.issue  = 1'b1;
                u.cond   = COND_MORE;
                u.target = STEP_SCAN;
            end
            STEP_DRAIN0: begin
                u.cond   = COND_ALWAYS;
                u.target = STEP_DRAIN1;
            end
            STEP_DRAIN1: begin
                u.cond   = COND_ALWAYS;
                u.target = STEP_EMIT;
            end
            STEP_EMIT: begin
                u.out_load = 1'b1;
                u.cond     = COND_OUT_BUSY;
                u.target   = STEP_EMIT;
            end
            STEP_RETURN: begin
                u.cond   = COND_ALWAYS;
                u.target = STEP_FETCH;
            end
            default: begin
                u.cond   = COND_ALWAYS;
                u.target = STEP_FETCH;
            end
        endcase
        return u;
    endfunction

endpackage

>>> design/nearest_palette_color_search_core.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data  (t_in_req: load or pixel)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_res: index, distance)
//
// A palette load leaves the input side open. A pixel holds it through the scan,
// which reads one palette entry a cycle from the single read port of the store,
// and through the drain, emit and return steps; then the next request may be taken.
// Reset clears the sequencer, the pipeline flags, the output flag and the entry
// valid bits; an entry never loaded reads as black, so no clearing pass is run.
// The output register holds its result while the output side stalls; the next
// request is taken meanwhile, and only a new result waits for the register.
module nearest_palette_color_search_core import npcs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    // Sequencer: the control word of the current step drives the datapath.
    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_uop              w_uop;
    logic              w_take;

    logic w_in_acc;
    logic w_pix_acc;
    logic w_load_acc;
    logic w_last;
    logic w_out_free;
    logic w_out_load;

    // Palette store with one valid bit per entry standing in for the reset clear.
    logic [RGB_W-1:0]        r_pal_mem [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0] r_pal_vld;

    // Scan pipeline: read, square, accumulate.
    logic [PAL_AW-1:0] r_addr;
    logic [RGB_W-1:0]  r_pix;
    logic [RGB_W-1:0]  r_rd_data;
    logic              r_rd_vld;
    logic              r_s1_vld;
    logic              r_s2_vld;
    logic [PAL_AW-1:0] r_s1_idx;
    logic [PAL_AW-1:0] r_s2_idx;
    logic [SQ_W-1:0]   r_sq_r;
    logic [SQ_W-1:0]   r_sq_g;
    logic [SQ_W-1:0]   r_sq_b;
    logic [DIST_W-1:0] r_best_dist;
    logic [PAL_AW-1:0] r_best_idx;

    logic [RGB_W-1:0]  w_ent;
    logic [CH_W-1:0]   w_dr;
    logic [CH_W-1:0]   w_dg;
    logic [CH_W-1:0]   w_db;
    logic [DIST_W-1:0] w_sum;

    logic     r_out_valid;
    t_out_res r_out_data;

    assign w_uop      = uop_rom(r_pc);
    assign o_in_stall = !w_uop.ready;
    assign w_in_acc   = i_in_valid && w_uop.ready;
    assign w_pix_acc  = w_in_acc && (i_in_data.op == OP_PIXEL);
    // Loads to an entry beyond the palette size are dropped.
    assign w_load_acc = w_in_acc && (i_in_data.op == OP_LOAD) &&
                        ({1'b0, i_in_data.entry_index} < (IDX_W + 1)'(PALETTE_SIZE));
    assign w_last     = (r_addr == PAL_AW'(PALETTE_SIZE - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = w_uop.out_load && w_out_free;

    always_comb begin
        unique case (w_uop.cond)
            COND_ALWAYS:   w_take = 1'b1;
            COND_NO_PIXEL: w_take = !w_pix_acc;
            COND_MORE:     w_take = !w_last;
            COND_OUT_BUSY: w_take = !w_out_free;
            default:       w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uop.target : r_pc + STEP_W'(1);
    end

    // Squared distance of the fetched entry; an entry never loaded is black.
    always_comb begin
        w_ent = r_rd_vld ? r_rd_data : '0;
        w_dr  = (w_ent[23:16] >= r_pix[23:16]) ? w_ent[23:16] - r_pix[23:16]
                                               : r_pix[23:16] - w_ent[23:16];
        w_dg  = (w_ent[15:8] >= r_pix[15:8]) ? w_ent[15:8] - r_pix[15:8]
                                             : r_pix[15:8] - w_ent[15:8];
        w_db  = (w_ent[7:0] >= r_pix[7:0]) ? w_ent[7:0] - r_pix[7:0]
                                           : r_pix[7:0] - w_ent[7:0];
    end

    assign w_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_FETCH;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pal_vld   <= '0;
        end else begin
            r_pc     <= n_pc;
            r_s1_vld <= w_uop.issue;
            r_s2_vld <= r_s1_vld;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_load_acc) begin
                r_pal_vld[i_in_data.entry_index[PAL_AW-1:0]] <= 1'b1;
            end
        end
    end

    // Palette store: one write port for loads, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (w_load_acc) begin
            r_pal_mem[i_in_data.entry_index[PAL_AW-1:0]] <=
                {i_in_data.red, i_in_data.green, i_in_data.blue};
        end
        r_rd_data <= r_pal_mem[r_addr];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_pal_vld[r_addr];
        r_s1_idx <= r_addr;
        r_s2_idx <= r_s1_idx;
        r_sq_r   <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_g   <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_b   <= SQ_W'(w_db) * SQ_W'(w_db);

        if (w_pix_acc) begin
            r_pix  <= {i_in_data.red, i_in_data.green, i_in_data.blue};
            r_addr <= '0;
        end else if (w_uop.issue && !w_last) begin
            r_addr <= r_addr + PAL_AW'(1);
        end

        // Strict compare keeps the lowest index on a tie.
        if (w_pix_acc) begin
            r_best_dist <= START_BEST;
            r_best_idx  <= '0;
        end else if (r_s2_vld && (w_sum < r_best_dist)) begin
            r_best_dist <= w_sum;
            r_best_idx  <= r_s2_idx;
        end

        if (w_out_load) begin
            r_out_data.color_index <= IDX_W'(r_best_idx);
            r_out_data.distance    <= r_best_dist;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> design/npcs_chk.sv
module npcs_chk import npcs_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_in_req  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_res o_out_data
);

    // A held result must not change while the output side stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // A pixel request starts a scan, so the input side must stall next cycle.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == OP_PIXEL |=> o_in_stall)
        else $error("input taken during a palette scan");

    // A load leaves the input side open for the next request.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == OP_LOAD |=> !o_in_stall)
        else $error("load request held up the input side");

    // A new result only appears at the end of a scan.
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a scan");

    // No squared distance exceeds three full-scale channel differences.
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.distance <= DIST_W'(195075))
        else $error("distance out of range");

endmodule

bind nearest_palette_color_search_core npcs_chk u_npcs_chk (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import npcs_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_PER_PHASE = 450;
    // The tail after the last result covers one full palette search and
    // some margin.
    localparam int TAIL_CYCLES      = PALETTE_SIZE + 40;
    localparam int CYCLE_LIMIT      = 3_000_000;
    // Farther than any colour can be from any palette entry.
    localparam int FAR_DISTANCE     = 3 * 256 * 256;

    // One line of the directed table: the request and, where the answer is
    // obvious, the match typed in by hand.
    typedef struct packed {
        t_in_req  req;
        logic     typed;
        t_out_res want;
    } t_plan_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_res o_out_data;

    nearest_palette_color_search_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Our own copy of the palette, packed as {red, green, blue}.
    logic [RGB_W-1:0] shadow_palette [PALETTE_SIZE];
    // Matches predicted for accepted pixel requests, oldest first.
    t_out_res         pending_matches [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int load_count     = 0;
    int pixel_count    = 0;
    int match_count    = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    // The search walks every entry in order and keeps a new best only when it
    // is strictly closer, so the lowest index wins a tie.
    function automatic t_out_res nearest_entry(input t_in_req px);
        t_out_res best;
        int       best_dist;
        int       dr;
        int       dg;
        int       db;
        int       sq_sum;
        best_dist         = FAR_DISTANCE;
        best.color_index  = '0;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            dr     = int'(shadow_palette[i][23:16]) - int'(px.red);
            dg     = int'(shadow_palette[i][15:8])  - int'(px.green);
            db     = int'(shadow_palette[i][7:0])   - int'(px.blue);
            sq_sum = dr * dr + dg * dg + db * db;
            if (sq_sum < best_dist) begin
                best_dist        = sq_sum;
                best.color_index = IDX_W'(i);
            end
        end
        best.distance = DIST_W'(best_dist);
        return best;
    endfunction

    // Moves a channel a few steps either way without leaving 0 .. 255.
    function automatic logic [CH_W-1:0] nudge(input logic [CH_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return CH_W'(v);
    endfunction

    function automatic t_plan_row plan_row(input logic op, input int idx, input int r,
                                           input int g, input int b, input logic typed,
                                           input int want_idx, input int want_dist);
        t_plan_row row;
        row.req.op                = op;
        row.req.entry_index       = IDX_W'(idx);
        row.req.red               = CH_W'(r);
        row.req.green             = CH_W'(g);
        row.req.blue              = CH_W'(b);
        row.typed                 = typed;
        row.want.color_index      = IDX_W'(want_idx);
        row.want.distance         = DIST_W'(want_dist);
        return row;
    endfunction

    // Offers one request and returns at the falling edge after it has been
    // taken. Valid stays high into the next call unless that call idles, so
    // back-to-back requests see no gap.
    task automatic send_request(input t_in_req req, input logic typed,
                                input t_out_res want);
        t_out_res guess;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        // Accepted at this edge: update the shadow palette or predict.
        if (req.op == OP_LOAD) begin
            if (int'(req.entry_index) < PALETTE_SIZE) begin
                shadow_palette[req.entry_index] = {req.red, req.green, req.blue};
            end
            load_count++;
        end else begin
            guess           = typed ? want : nearest_entry(req);
            pending_matches = {pending_matches, guess};
            pixel_count++;
        end
        @(negedge i_clk);
    endtask

    // Holds the sender back until every predicted match has been seen.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_matches.size() != 0) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Random traffic is mostly bursts of palette loads followed by a few
    // pixels aimed at what was just loaded, so that exact hits, near misses
    // and ties between duplicate colours come up often. About one round in
    // ten sends a single request of pure noise instead of a burst.
    task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
        t_in_req          req;
        logic [RGB_W-1:0] burst [$];
        logic [RGB_W-1:0] colour;
        int               sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent           = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 10) begin
                req.op                          = logic'($urandom_range(1));
                req.entry_index                 = IDX_W'($urandom);
                {req.red, req.green, req.blue}  = RGB_W'($urandom);
                send_request(req, 1'b0, '0);
                sent++;
            end else begin
                burst.delete();
                repeat ($urandom_range(1, 10)) begin
                    req.op          = OP_LOAD;
                    req.entry_index = IDX_W'($urandom);
                    // Now and then repeat a colour so that two entries tie.
                    if (burst.size() != 0 && $urandom_range(4) == 0) begin
                        colour = burst[$urandom_range(burst.size() - 1)];
                    end else begin
                        colour = RGB_W'($urandom);
                    end
                    {req.red, req.green, req.blue} = colour;
                    burst = {burst, colour};
                    send_request(req, 1'b0, '0);
                    sent++;
                end
                repeat ($urandom_range(1, 5)) begin
                    req.op          = OP_PIXEL;
                    req.entry_index = IDX_W'($urandom);
                    colour          = burst[$urandom_range(burst.size() - 1)];
                    case ($urandom_range(3))
                        0: begin
                            {req.red, req.green, req.blue} = colour;
                        end
                        1: begin
                            req.red   = nudge(colour[23:16]);
                            req.green = nudge(colour[15:8]);
                            req.blue  = nudge(colour[7:0]);
                        end
                        2: begin
                            {req.red, req.green, req.blue} = RGB_W'($urandom);
                        end
                        default: begin
                            req.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                            req.green = $urandom_range(1) ? 8'hFF : 8'h00;
                            req.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
                        end
                    endcase
                    send_request(req, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // The receiver decides afresh each cycle whether to hold off.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every result taken is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_res oldest;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual index %0d distance %0d",
                         $time, o_out_data.color_index, o_out_data.distance);
                mismatch_count++;
            end else begin
                oldest = pending_matches.pop_front();
                match_count++;
                if (o_out_data.color_index !== oldest.color_index) begin
                    $display("%0t: color_index expected %0d actual %0d", $time,
                             oldest.color_index, o_out_data.color_index);
                    mismatch_count++;
                end
                if (o_out_data.distance !== oldest.distance) begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             oldest.distance, o_out_data.distance);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake must not leave the run spinning forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results outstanding", $time,
                     pending_matches.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_plan_row plan [$];
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            shadow_palette[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening. Straight after reset every entry is black, so
        // black is an exact hit at entry 0 and white is as far as it gets.
        plan = {plan, plan_row(OP_PIXEL,   0,   0,   0,   0, 1'b1,   0,      0)};
        // The index field of a pixel request is ignored.
        plan = {plan, plan_row(OP_PIXEL, 255, 255, 255, 255, 1'b1,   0, 195075)};
        plan = {plan, plan_row(OP_LOAD,  255, 255, 255, 255, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL,   0, 255, 255, 255, 1'b1, 255,      0)};
        // White at both ends of the palette: the lower index must win.
        plan = {plan, plan_row(OP_LOAD,    0, 255, 255, 255, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL,   0, 255, 255, 255, 1'b1,   0,      0)};
        // Entries never loaded still count as black.
        plan = {plan, plan_row(OP_PIXEL,   0,   0,   0,   0, 1'b1,   1,      0)};
        plan = {plan, plan_row(OP_LOAD,    1,  10,  20,  30, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_LOAD,    2,  10,  20,  30, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL,   0,  12,  20,  30, 1'b1,   1,      4)};
        // Alternating bit patterns on every channel.
        plan = {plan, plan_row(OP_LOAD,    3, 'h55, 'hAA, 'h55, 1'b0, 0,     0)};
        plan = {plan, plan_row(OP_LOAD,    4, 'hAA, 'h55, 'hAA, 1'b0, 0,     0)};
        plan = {plan, plan_row(OP_PIXEL, 'h5A, 'h55, 'hAA, 'h55, 1'b1, 3,    0)};
        plan = {plan, plan_row(OP_PIXEL, 'hA5, 'hAA, 'h55, 'hAA, 1'b1, 4,    0)};
        plan = {plan, plan_row(OP_LOAD,  128, 128,   0, 255, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL,   0, 128,   0, 250, 1'b0,   0,      0)};
        // Overwrites of entries already in use.
        plan = {plan, plan_row(OP_LOAD,  255,   0,   0,   0, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL,   0, 255,   0,   0, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_LOAD,    3, 255, 255,   0, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL, 255, 200, 200,  10, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL,   0,   0, 255,   0, 1'b0,   0,      0)};
        plan = {plan, plan_row(OP_PIXEL,  77,   0,   0, 255, 1'b0,   0,      0)};
        foreach (plan[k]) begin
            send_request(plan[k].req, plan[k].typed, plan[k].want);
        end
        wait_for_drain();

        // Random traffic under four pacing regimes, each phase ending with
        // the sender held back until the last match is in.
        run_phase(RANDOM_PER_PHASE,  0,  0);
        wait_for_drain();
        run_phase(RANDOM_PER_PHASE, 67,  0);
        wait_for_drain();
        run_phase(RANDOM_PER_PHASE,  0, 67);
        wait_for_drain();
        run_phase(RANDOM_PER_PHASE, 12, 12);
        wait_for_drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d palette loads and %0d pixel searches; %0d matches were checked,",
                 load_count, pixel_count, match_count);
        $display("with sender gaps and receiver back-pressure varied across four phases.");
        if (mismatch_count == 0 && pending_matches.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
design/npcs_pkg.sv
design/nearest_palette_color_search_core.sv
design/npcs_chk.sv
bench/testbench.sv
